// File: hdl/tdpt_pkg.sv
`timescale 1ns / 1ps

package tdpt_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the candidate and set the divisor to three
    logic div_start;    // set up the divider for a new trial division
    logic div_step;     // one restoring division step
    logic next_div;     // advance the divisor to the next odd value
    logic set_verdict;  // record the outcome of the test
    logic verdict;      // outcome to record: one for prime
    logic publish;      // copy the value and verdict into the output register
  } tdpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below_two;     // candidate is zero or one
    logic is_two;        // candidate is exactly two
    logic is_even;       // candidate is even
    logic div_last;      // the divider is on its final step
    logic bound_passed;  // divisor exceeds the quotient, so its square exceeds the value
    logic rem_zero;      // the remainder of the last division is zero
  } tdpt_status_t;

endpackage

// File: hdl/tdpt_datapath.sv
`timescale 1ns / 1ps

module tdpt_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  tdpt_pkg::tdpt_cmd_t      cmd,
  input  logic [VALUE_WIDTH-1:0]   candidate,
  output tdpt_pkg::tdpt_status_t   status,
  output logic [VALUE_WIDTH-1:0]   tested_value,
  output logic                     is_prime
);
  import tdpt_pkg::*;

  localparam int CountWidth = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] divisor;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] quot;
  logic [CountWidth-1:0]  count;
  logic                   verdict;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;

  // One restoring division step: bring down the next bit of the dividend
  // and subtract the divisor where it fits.
  always_comb begin
    shifted = {rem, quot[VALUE_WIDTH-1]};
    fits    = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  // Working registers of the test.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value   <= candidate;
      divisor <= VALUE_WIDTH'(3);
    end
    if (cmd.next_div) begin
      divisor <= divisor + VALUE_WIDTH'(2);
    end
    if (cmd.div_start) begin
      rem   <= '0;
      quot  <= value;
      count <= CountWidth'(VALUE_WIDTH);
    end else if (cmd.div_step) begin
      rem   <= fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
      quot  <= {quot[VALUE_WIDTH-2:0], fits};
      count <= count - CountWidth'(1);
    end
    if (cmd.set_verdict) begin
      verdict <= cmd.verdict;
    end
  end

  // Output register, so that a new candidate can be taken while a result waits.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      tested_value <= value;
      is_prime     <= verdict;
    end
  end

  // Status for the controller.
  always_comb begin
    status.below_two    = value[VALUE_WIDTH-1:1] == '0;
    status.is_two       = value == VALUE_WIDTH'(2);
    status.is_even      = ~value[0];
    status.div_last     = count == CountWidth'(1);
    status.bound_passed = divisor > quot;
    status.rem_zero     = rem == '0;
  end

endmodule

// File: hdl/tdpt_ctrl.sv
`timescale 1ns / 1ps

module tdpt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   candidate_valid,
  output logic                   candidate_ready,
  output logic                   result_valid,
  input  logic                   result_ready,
  input  tdpt_pkg::tdpt_status_t status,
  output tdpt_pkg::tdpt_cmd_t    cmd
);
  import tdpt_pkg::*;

  typedef enum logic [4:0] {
    IDLE     = 5'b00001,
    CLASSIFY = 5'b00010,
    DIVIDE   = 5'b00100,
    CHECK    = 5'b01000,
    FINISH   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   result_valid_next;

  // Next state and commands.
  always_comb begin
    state_next        = state;
    cmd               = '0;
    result_valid_next = result_valid && !result_ready;
    case (state)
      IDLE: begin
        if (candidate_valid) begin
          cmd.load   = 1'b1;
          state_next = CLASSIFY;
        end
      end
      CLASSIFY: begin
        if (status.below_two || (status.is_even && !status.is_two)) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b0;
          state_next      = FINISH;
        end else if (status.is_two) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b1;
          state_next      = FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = DIVIDE;
        end
      end
      DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = CHECK;
        end
      end
      CHECK: begin
        if (status.bound_passed) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b1;
          state_next      = FINISH;
        end else if (status.rem_zero) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b0;
          state_next      = FINISH;
        end else begin
          cmd.next_div  = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = DIVIDE;
        end
      end
      FINISH: begin
        // Hand over once the output register is free or being emptied.
        if (!result_valid || result_ready) begin
          cmd.publish       = 1'b1;
          result_valid_next = 1'b1;
          state_next        = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State and output flag registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  assign candidate_ready = state == IDLE;

endmodule

// File: hdl/trial_division_prime_test.sv
`timescale 1ns / 1ps
// Channel     Handshake                        Payload
// candidate   candidate_valid/candidate_ready  candidate
// result      result_valid/result_ready        tested_value, is_prime
//
// A candidate is first classified; zero, one and even values need no division. For
// other values each odd trial divisor runs the bit-serial divider for VALUE_WIDTH
// steps, followed by the bound and remainder check. A new candidate is taken while
// the previous result waits; a finished test stalls only while the output register
// is full. Reset is synchronous and clears the controller only.
module trial_division_prime_test #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   candidate_valid,
  output logic                   candidate_ready,
  input  logic [VALUE_WIDTH-1:0] candidate,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [VALUE_WIDTH-1:0] tested_value,
  output logic                   is_prime
);
  import tdpt_pkg::*;

  tdpt_cmd_t    cmd;
  tdpt_status_t status;

  // Sequencer.
  tdpt_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .candidate_valid (candidate_valid),
    .candidate_ready (candidate_ready),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .status          (status),
    .cmd             (cmd)
  );

  // Divider, divisor and output register.
  tdpt_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .candidate    (candidate),
    .status       (status),
    .tested_value (tested_value),
    .is_prime     (is_prime)
  );

`ifndef SYNTHESIS
  // A value reported prime is at least two.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && is_prime |-> tested_value[VALUE_WIDTH-1:1] != '0)
    else $error("prime reported for zero or one");

  // A value reported prime is odd or exactly two.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && is_prime |-> tested_value[0] || tested_value == VALUE_WIDTH'(2))
    else $error("prime reported for an even value other than two");

  // After a transaction on the candidate channel the block is busy.
  assert property (@(posedge clk) disable iff (rst)
    candidate_valid && candidate_ready |=> !candidate_ready)
    else $error("candidate taken while a test was under way");
`endif

endmodule

// File: bench/trial_division_prime_test_tb.sv
`timescale 1ns / 1ps

module trial_division_prime_test_tb;

  localparam int VW = 32;

  // Gives up well beyond the slowest clean run, including the longest trial divisions.
  localparam int RUN_LIMIT_NS = 400_000_000;
  localparam int RANDOM_ITEMS = 100;
  localparam int TAIL_CYCLES  = 60;

  logic          clk = 1'b0;
  logic          rst;
  logic          candidate_valid;
  logic          candidate_ready;
  logic [VW-1:0] candidate;
  logic          result_valid;
  logic          result_ready;
  logic [VW-1:0] tested_value;
  logic          is_prime;

  // While set, neither side inserts any idle cycles.
  bit steady = 1'b0;

  // Holds the verdicts still owed by the block and checks each one as it arrives.
  class prime_scoreboard;
    typedef struct {
      logic [VW-1:0] value;
      bit            prime;
    } verdict_t;

    verdict_t verdict_q[$];
    int       mismatches = 0;
    int       tested     = 0;
    int       primes     = 0;

    // Trial division by odd divisors while the divisor does not exceed n / d.
    function bit trial_prime(logic [VW-1:0] n);
      longint unsigned v;
      longint unsigned d;
      v = n;
      if (v < 2) return 1'b0;
      if (v == 2) return 1'b1;
      if (v[0] == 1'b0) return 1'b0;
      for (d = 3; d <= v / d; d += 2) begin
        if (v % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_candidate(logic [VW-1:0] n);
      verdict_t x;
      x.value = n;
      x.prime = trial_prime(n);
      verdict_q.push_back(x);
    endfunction

    function void check_result(logic [VW-1:0] value, logic prime);
      verdict_t x;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with nothing outstanding: tested_value=%0d is_prime=%b",
                   $realtime, value, prime);
        return;
      end
      x = verdict_q.pop_front();
      tested++;
      if (x.prime) primes++;
      if (value !== x.value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] tested_value mismatch: expected %0d, got %0d",
                   $realtime, x.value, value);
      end
      if (prime !== x.prime) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] is_prime mismatch for %0d: expected %b, got %b",
                   $realtime, x.value, x.prime, prime);
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  prime_scoreboard sb = new();

  trial_division_prime_test #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .candidate_valid (candidate_valid),
    .candidate_ready (candidate_ready),
    .candidate       (candidate),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .tested_value    (tested_value),
    .is_prime        (is_prime)
  );

  always #10 clk = ~clk;

  // Half the time no gap, often a short one, now and then a long one.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one candidate and returns at the edge where the transaction completes.
  task automatic send_candidate(logic [VW-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      candidate_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    candidate_valid <= 1'b1;
    candidate       <= value;
    do @(posedge clk); while (!candidate_ready);
  endtask

  // Stops offering and waits until every outstanding verdict has been checked.
  task automatic drain();
    candidate_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Random candidates kept cheap enough to finish in reasonable time; the wide ones
  // are even or multiples of three so that they still exercise every bit.
  function logic [VW-1:0] random_candidate();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 32'($urandom_range(1, 2047) * 2 + 1);
    if (r < 55) return 32'($urandom_range(0, 65535)) | 32'd1;
    if (r < 62) return 32'($urandom_range(0, (1 << 20) - 1)) | 32'd1;
    if (r < 80) return 32'($urandom_range(0, 32'd1431655765)) * 32'd3;
    if (r < 95) return $urandom() & ~32'd1;
    return 32'($urandom_range(0, 3));
  endfunction

  // Observes both channels on the same edge the transactions complete.
  always @(posedge clk) begin
    if (!rst) begin
      if (candidate_valid && candidate_ready) sb.note_candidate(candidate);
      if (result_valid && result_ready) sb.check_result(tested_value, is_prime);
    end
  end

  // Result side: alternating runs of readiness and stalls.
  initial begin
    int gap;
    result_ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [VW-1:0] edge_values[$];
    rst             = 1'b1;
    candidate_valid = 1'b0;
    candidate       = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero, one, two, small odd primes and squares of primes on the divisor bound,
    // all-ones and all-zeros patterns, the top bit, and a few slower primes.
    edge_values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25,
                    32'd49, 32'd97, 32'd121, 32'd1001, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                    32'h8000_0000, 32'h5555_5555, 32'd196611, 32'd65521, 32'd65537,
                    32'd1018081, 32'd16777213};
    foreach (edge_values[i]) send_candidate(edge_values[i]);

    // Let everything settle before the random part starts.
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 40 && i < 60);
      send_candidate(random_candidate());
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d verdicts (%0d prime): edge values, then %0d random candidates",
             sb.tested, sb.primes, RANDOM_ITEMS);
    $display("with random stalls on both channels and one back-to-back stretch.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("trial_division_prime_test_tb: done, clean");
    end else begin
      $display("trial_division_prime_test_tb: done, errors");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #(RUN_LIMIT_NS);
    $display("trial_division_prime_test_tb: done, errors");
    $finish;
  end

endmodule
